// File: rtl/lkv_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the lru key-value cache
package lkv_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int SLOT_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 5;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_UPDATE
    } lkv_state_t;

    typedef struct packed {
        logic                    command;
        logic signed [KEY_W-1:0] lookup_key;
        logic signed [VAL_W-1:0] store_value;
    } lkv_req_t;

    typedef struct packed {
        logic                    found;
        logic signed [VAL_W-1:0] read_value;
        logic                    evicted;
        logic signed [KEY_W-1:0] evicted_key;
    } lkv_rsp_t;

    typedef struct packed {
        logic load_req;
        logic match_en;
        logic update_en;
    } lkv_cmd_t;

endpackage

// File: rtl/lkv_ctrl.sv
`timescale 1ns / 1ps
// controller state machine for the lru key-value cache
module lkv_ctrl
    import lkv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output lkv_cmd_t cmd
);

    lkv_state_t state_reg;
    lkv_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                cmd.match_en = 1'b1;
                state_next   = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                // result slot must be free or draining this cycle
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.update_en = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.update_en)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign rsp_valid = out_valid_reg;

endmodule

// File: rtl/lkv_datapath.sv
`timescale 1ns / 1ps
// key match, recency list and entry storage for the lru key-value cache
module lkv_datapath
    import lkv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  lkv_cmd_t         cmd,
    input  lkv_req_t         req,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_data,
    output lkv_rsp_t         rsp
);

    lkv_req_t                 req_reg;
    logic [KEY_W-1:0]         keys_reg   [MAX_ENTRIES];
    logic [VAL_W-1:0]         values_reg [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]   valid_reg;
    logic [SLOT_W-1:0]        order_reg  [MAX_ENTRIES];
    logic [SLOT_W-1:0]        order_next [MAX_ENTRIES];
    logic [OCC_W-1:0]         occ_reg;
    logic [CAP_W-1:0]         cap_reg;
    logic [MAX_ENTRIES-1:0]   hit_vec_reg;
    logic [MAX_ENTRIES-1:0]   hit_vec_next;
    lkv_rsp_t                 rsp_reg;
    lkv_rsp_t                 rsp_next;

    logic [MAX_ENTRIES-1:0]   pos_hit;
    logic                     found;
    logic [SLOT_W-1:0]        hit_pos;
    logic [OCC_W-1:0]         eff_cap;
    logic                     is_put;
    logic                     evict;
    logic [OCC_W-1:0]         ins_occ;
    logic [SLOT_W-1:0]        move_pos;
    logic [SLOT_W-1:0]        slot;
    logic                     do_move;

    // parallel key compare against every live slot
    always_comb
    begin
        for (int s = 0; s < MAX_ENTRIES; s++)
            hit_vec_next[s] = valid_reg[s] && (keys_reg[s] == req_reg.lookup_key);
    end

    always_comb
    begin
        is_put = (req_reg.command == CMD_PUT);

        for (int p = 0; p < MAX_ENTRIES; p++)
            pos_hit[p] = (OCC_W'(p) < occ_reg) && hit_vec_reg[order_reg[p]];
        found   = |pos_hit;
        hit_pos = '0;
        for (int p = 0; p < MAX_ENTRIES; p++)
            if (pos_hit[p])
                hit_pos = hit_pos | SLOT_W'(p);

        // zero acts as one, large values saturate
        if (cap_reg == '0)
            eff_cap = OCC_W'(1);
        else if (int'(cap_reg) > MAX_ENTRIES)
            eff_cap = OCC_W'(MAX_ENTRIES);
        else
            eff_cap = OCC_W'(cap_reg);

        evict    = !found && is_put && (occ_reg >= eff_cap) && (occ_reg != '0);
        ins_occ  = evict ? (occ_reg - OCC_W'(1)) : occ_reg;
        move_pos = found ? hit_pos : ins_occ[SLOT_W-1:0];
        slot     = order_reg[move_pos];
        do_move  = found || is_put;

        // move to front
        for (int p = 0; p < MAX_ENTRIES; p++)
        begin
            if (!do_move)
                order_next[p] = order_reg[p];
            else if (p == 0)
                order_next[p] = slot;
            else if (SLOT_W'(p) <= move_pos)
                order_next[p] = order_reg[p-1];
            else
                order_next[p] = order_reg[p];
        end

        rsp_next.found       = found;
        rsp_next.read_value  = (found && !is_put) ? values_reg[slot] : '0;
        rsp_next.evicted     = evict;
        rsp_next.evicted_key = evict ? keys_reg[slot] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            cap_reg   <= CAP_RESET;
            for (int p = 0; p < MAX_ENTRIES; p++)
                order_reg[p] <= SLOT_W'(p);
        end
        else
        begin
            if (cfg_we && (occ_reg == '0))
                cap_reg <= cfg_data;
            if (cmd.update_en)
            begin
                for (int p = 0; p < MAX_ENTRIES; p++)
                    order_reg[p] <= order_next[p];
                if (!found && is_put)
                begin
                    valid_reg[slot] <= 1'b1;
                    if (!evict)
                        occ_reg <= occ_reg + OCC_W'(1);
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
            req_reg <= req;
        if (cmd.match_en)
            hit_vec_reg <= hit_vec_next;
        if (cmd.update_en)
        begin
            rsp_reg <= rsp_next;
            if (is_put)
                values_reg[slot] <= req_reg.store_value;
            if (!found && is_put)
                keys_reg[slot] <= req_reg.lookup_key;
        end
    end

    assign rsp = rsp_reg;

endmodule

// File: rtl/lru_key_value_cache.sv
`timescale 1ns / 1ps
// top level of the fully associative lru key-value cache
//
// request channel (req_valid/req_ready/req) carries a get or a put with key
// and value; response channel (rsp_valid/rsp_ready/rsp) returns exactly one
// transaction per request, in order: found flag, read value on a get hit,
// and the evicted key when a put miss pushes out the least recent entry
// sequence: an accepted request is registered, then matched (all keys
// compared in parallel), then the store and recency list update and the
// response is loaded into the output register; a new request is taken
// only once the update is done, so transactions do not overlap, as set by
// the three-state controller (accept, match, update)
// the output register decouples the sides: if the receiver stalls, the next
// request is still accepted and matched, and holds in the update state
// until the pending response is taken
// reset: store empty, recency list in slot order, capacity register 16;
// no clearing pass is needed since the valid bits are flip-flops
// capacity (cfg_we/cfg_data) is taken only while the store is empty;
// zero acts as one and values above 16 saturate
module lru_key_value_cache
    import lkv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  lkv_req_t         req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output lkv_rsp_t         rsp,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_data
);

    lkv_cmd_t cmd;

    // sequencing of accept, match and update
    lkv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    // entry storage, key compare and recency list
    lkv_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .rsp      (rsp)
    );

endmodule
